### rtl/ilir_pkg.sv
package ilir_pkg;

    // Storage sizing.
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    // Field widths of the request and result items.
    localparam int FUNC_W      = 2;
    localparam int POS_W       = 8;
    localparam int ELEM_W      = 32;
    localparam int DOUT_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // Internal widths that follow from the capacity.
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W   = ($clog2(CAPACITY) > POS_W) ? $clog2(CAPACITY) : POS_W;
    localparam int CMP_W   = IDX_W + 1;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [COUNT_W-1:0]    count_t;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SET    = 2'd1,
        OP_GET    = 2'd2,
        OP_REMOVE = 2'd3
    } op_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_e;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] element;
    } in_item_t;

    typedef struct packed {
        logic [DOUT_W-1:0]      data_out;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] count_out;
        logic                   is_empty;
    } out_item_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic  shift_up;
        logic  shift_down;
        logic  write;
        idx_t  pos;
        word_t word;
    } cell_cmd_t;

endpackage

### rtl/indexed_list_insert_remove_top.sv
// Indexed list of up to 64 words held in a row of cells. Each request (insert,
// set, get, remove) is answered by one result in the cycle after it is accepted, and
// a new request can be accepted in every cycle while the result register drains;
// insert and remove move every later entry in the same cycle because each cell
// loads from its neighbor in parallel. An insert past the end appends, an insert
// into a full list reports full, and set, get or remove at an index at or beyond
// the count report out of range with zero data. No clearing pass is needed after
// reset.
module indexed_list_insert_remove_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ilir_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ilir_pkg::out_item_t out_data
);
    import ilir_pkg::*;

    logic      in_xfer;
    op_e       op;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic      full;
    logic      in_range;
    idx_t      ins_pos;
    cell_cmd_t cmd;
    word_t     rd_word;

    count_t    count_reg;
    count_t    count_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;
    out_item_t out_next;

    // The result register frees up when it is empty or being taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Decode the request against the current count.
    assign op       = op_e'(in_data.func);
    assign pos_ext  = CMP_W'(in_data.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign full     = (count_reg == COUNT_W'(CAPACITY));
    assign in_range = (pos_ext < cnt_ext);
    assign ins_pos  = (pos_ext > cnt_ext) ? IDX_W'(count_reg) : IDX_W'(in_data.position);

    // Build the command for the cell chain.
    always_comb
    begin
        cmd            = '0;
        cmd.word       = DATA_WIDTH'(in_data.element);
        cmd.pos        = IDX_W'(in_data.position);
        unique case (op)
            OP_INSERT:
            begin
                cmd.pos      = ins_pos;
                cmd.shift_up = in_xfer && !full;
                cmd.write    = in_xfer && !full;
            end
            OP_SET:
            begin
                cmd.write = in_xfer && in_range;
            end
            OP_REMOVE:
            begin
                cmd.shift_down = in_xfer && in_range;
            end
            default:
            begin
                cmd.write = 1'b0;
            end
        endcase
    end

    ilir_chain u_chain (
        .clk       (clk),
        .cmd       (cmd),
        .read_pos  (IDX_W'(in_data.position)),
        .read_data (rd_word)
    );

    // Count update and result formation.
    always_comb
    begin
        count_next        = count_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        if (in_xfer)
        begin
            out_valid_next     = 1'b1;
            out_next.data_out  = '0;
            out_next.status    = ST_OK;
            unique case (op)
                OP_INSERT:
                begin
                    if (full)
                    begin
                        out_next.status = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                OP_SET:
                begin
                    if (!in_range)
                    begin
                        out_next.status = ST_RANGE;
                    end
                end
                OP_GET:
                begin
                    if (!in_range)
                    begin
                        out_next.status = ST_RANGE;
                    end
                    else
                    begin
                        out_next.data_out = DOUT_W'(rd_word);
                    end
                end
                OP_REMOVE:
                begin
                    if (!in_range)
                    begin
                        out_next.status = ST_RANGE;
                    end
                    else
                    begin
                        out_next.data_out = DOUT_W'(rd_word);
                        count_next        = count_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    out_next.status = ST_OK;
                end
            endcase
            out_next.count_out = COUNT_OUT_W'(count_next);
            out_next.is_empty  = (count_next == '0);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/ilir_cell.sv
module ilir_cell (
    input  logic              clk,
    input  ilir_pkg::idx_t    cell_index,
    input  ilir_pkg::cell_cmd_t cmd,
    input  ilir_pkg::idx_t    read_pos,
    input  ilir_pkg::word_t   left_data,
    input  ilir_pkg::word_t   right_data,
    output ilir_pkg::word_t   data,
    output ilir_pkg::word_t   read_data
);
    import ilir_pkg::*;

    word_t data_reg;
    word_t data_next;

    // Pick the new content: the addressed cell takes the written word, cells above
    // the insert point take their lower neighbor, cells at or above the removal
    // point take their upper neighbor.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.write && (cell_index == cmd.pos))
        begin
            data_next = cmd.word;
        end
        else if (cmd.shift_up && (cell_index > cmd.pos))
        begin
            data_next = left_data;
        end
        else if (cmd.shift_down && (cell_index >= cmd.pos))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

    // Only the addressed cell contributes to the read bus.
    assign read_data = (cell_index == read_pos) ? data_reg : '0;

endmodule

### rtl/ilir_chain.sv
module ilir_chain (
    input  logic                clk,
    input  ilir_pkg::cell_cmd_t cmd,
    input  ilir_pkg::idx_t      read_pos,
    output ilir_pkg::word_t     read_data
);
    import ilir_pkg::*;

    word_t cell_data [CAPACITY];
    word_t cell_rd   [CAPACITY];

    // One cell per list slot, each linked to its two neighbors.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        word_t left_w;
        word_t right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = cell_data[g+1];
        end

        ilir_cell u_cell (
            .clk        (clk),
            .cell_index (IDX_W'(g)),
            .cmd        (cmd),
            .read_pos   (read_pos),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[g]),
            .read_data  (cell_rd[g])
        );
    end

    // Combine the per-cell read contributions; at most one is nonzero.
    always_comb
    begin
        read_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_data = read_data | cell_rd[i];
        end
    end

endmodule
